[rtl/core/gm_pkg.sv]
// Shared types and constants of the glob wildcard matcher.
// No dependencies; used by gm_in_if, gm_step, the matcher top level and the bench.
`default_nettype none

package gm_pkg;

  // One byte of pattern or text
  typedef logic [7:0] byte_t;

  // Item kind carried with each input word
  typedef logic [1:0] mode_t;

  localparam mode_t MODE_PAT_APPEND = 2'd0;
  localparam mode_t MODE_TEXT       = 2'd1;
  localparam mode_t MODE_TEXT_END   = 2'd2;
  localparam mode_t MODE_PAT_CLEAR  = 2'd3;

  // Wildcard bytes
  localparam byte_t STAR_BYTE     = 8'h2A;
  localparam byte_t QUESTION_BYTE = 8'h3F;

endpackage : gm_pkg

`default_nettype wire

[rtl/core/gm_in_if.sv]
// Input channel of the glob matcher: valid/ready plus mode and byte.
// Depends on gm_pkg for the payload types.
`default_nettype none

interface gm_in_if;
  logic           valid;
  logic           ready;
  gm_pkg::mode_t  mode;
  gm_pkg::byte_t  byte_in;

  modport source (output valid, output mode, output byte_in, input ready);
  modport sink   (input valid, input mode, input byte_in, output ready);
endinterface : gm_in_if

`default_nettype wire

[rtl/core/gm_out_if.sv]
// Result channel of the glob matcher: valid/ready plus match and overflow flags.
// No package dependency.
`default_nettype none

interface gm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface : gm_out_if

`default_nettype wire

[rtl/core/gm_star_close.sv]
// Star closure of the active position set: a log-depth prefix network
// (generate = active, propagate = star at the previous position). No package use.
`default_nettype none

module gm_star_close #(
  parameter int N = 32
) (
  input  wire logic [N:0]   act_in,
  input  wire logic [N-1:0] star_in,
  output logic      [N:0]   act_closed
);

  localparam int W   = N + 1;
  localparam int LVL = $clog2(W);

  logic [W-1:0] g_lvl [LVL+1];
  logic [W-1:0] p_lvl [LVL+1];

  // Kogge-Stone prefix: position j is reached from any active i <= j
  // when every position i..j-1 holds a star
  always_comb begin
    g_lvl[0] = act_in;
    p_lvl[0] = {star_in, 1'b0};
    for (int k = 0; k < LVL; k++) begin
      for (int j = 0; j < W; j++) begin
        if (j >= (1 << k)) begin
          g_lvl[k+1][j] = g_lvl[k][j] | (p_lvl[k][j] & g_lvl[k][j - (1 << k)]);
          p_lvl[k+1][j] = p_lvl[k][j] & p_lvl[k][j - (1 << k)];
        end else begin
          g_lvl[k+1][j] = g_lvl[k][j];
          p_lvl[k+1][j] = p_lvl[k][j];
        end
      end
    end
  end

  assign act_closed = g_lvl[LVL];

endmodule : gm_star_close

`default_nettype wire

[rtl/core/gm_step.sv]
// One text-byte step of the position automaton over a closed active set.
// Depends on gm_pkg for byte type and wildcard constants.
`default_nettype none

module gm_step #(
  parameter int N = 32,
  parameter int LEN_W = 6
) (
  input  wire gm_pkg::byte_t pat_in [N],
  input  wire logic [LEN_W-1:0] len_in,
  input  wire logic [N:0]  act_closed,
  input  wire gm_pkg::byte_t text_byte,
  output logic      [N:0]  act_next
);
  import gm_pkg::*;

  // Star keeps its position; '?' or an equal byte advances by one
  always_comb begin
    act_next = '0;
    for (int i = 0; i < N; i++) begin
      if ((LEN_W'(i) < len_in) && act_closed[i]) begin
        if (pat_in[i] == STAR_BYTE) begin
          act_next[i] = 1'b1;
        end else if ((pat_in[i] == QUESTION_BYTE) || (pat_in[i] == text_byte)) begin
          act_next[i+1] = 1'b1;
        end
      end
    end
  end

endmodule : gm_step

`default_nettype wire

[rtl/core/glob_wildcard_matcher.sv]
// Glob wildcard matcher: '*' and '?' whole-string matching of streamed text.
// Top level; depends on gm_pkg, gm_in_if, gm_out_if, gm_star_close, gm_step.
//
// Usage:
//  - in_ch carries one word per item: mode selects pattern append, text byte,
//    end of text or pattern clear; byte_in holds the pattern or text byte.
//  - Load the pattern with append words (bytes past MAX_PATTERN are dropped and
//    flagged), then stream text words and close with one end-of-text word.
//  - Each end-of-text word yields one word on out_ch: matched and
//    pattern_overflow. Other words yield nothing. Appends and clears rearm.
//  - Timing: a word is held in the input register and processed from there; its
//    result is registered in the result register as the word is taken.
//  - Throughput: one word per cycle unless an end-of-text word waits on out_ch;
//    each update: one star closure prefix, one byte compare per pattern position.
//  - When out_ch stalls, the result register holds; pattern and text words keep
//    flowing, and an end-of-text word waits in the input register until the
//    result register frees up, holding off in_ch behind it.
//  - Reset (rst_n low, synchronous) empties the pattern, clears the overflow
//    flag, arms position zero and drops any word in flight.
`default_nettype none

module glob_wildcard_matcher #(
  parameter int MAX_PATTERN = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  gm_in_if.sink     in_ch,
  gm_out_if.source  out_ch
);
  import gm_pkg::*;

  localparam int N     = MAX_PATTERN;
  localparam int LEN_W = $clog2(N + 1);

  // Input register
  logic              in_vld_r;
  mode_t             in_mode_r;
  byte_t             in_byte_r;

  // Matcher state
  byte_t             pat_r [N];
  logic [LEN_W-1:0]  len_r;
  logic [N:0]        act_r;
  logic              ovf_r;

  // Result register
  logic              out_vld_r;
  logic              out_matched_r;
  logic              out_ovf_r;

  logic              fire;
  logic              is_end;
  logic [N-1:0]      star_vec;
  logic [N:0]        act_closed;
  logic [N:0]        act_next;
  logic [N:0]        act_rearm;

  assign act_rearm = (N + 1)'(1);

  // Item in the input register advances unless it is an end of text
  // facing a full result register
  assign is_end = (in_mode_r == MODE_TEXT_END);
  assign fire   = in_vld_r && (!is_end || !out_vld_r || out_ch.ready);

  assign in_ch.ready = !in_vld_r || fire;

  // Star positions inside the stored pattern
  always_comb begin
    for (int i = 0; i < N; i++) begin
      star_vec[i] = (pat_r[i] == STAR_BYTE) && (LEN_W'(i) < len_r);
    end
  end

  gm_star_close #(.N(N)) u_close (
    .act_in     (act_r),
    .star_in    (star_vec),
    .act_closed (act_closed)
  );

  gm_step #(.N(N), .LEN_W(LEN_W)) u_step (
    .pat_in     (pat_r),
    .len_in     (len_r),
    .act_closed (act_closed),
    .text_byte  (in_byte_r),
    .act_next   (act_next)
  );

  // Input register load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_mode_r <= in_ch.mode;
      in_byte_r <= in_ch.byte_in;
    end
  end

  // Pattern store: written in order, never read past len_r
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (fire && (in_mode_r == MODE_PAT_APPEND) && (len_r == LEN_W'(i))) begin
        pat_r[i] <= in_byte_r;
      end
    end
  end

  // Length, overflow and active set update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      act_r <= act_rearm;
    end else if (fire) begin
      unique case (in_mode_r)
        MODE_PAT_APPEND: begin
          if (len_r < LEN_W'(N)) begin
            len_r <= len_r + LEN_W'(1);
          end else begin
            ovf_r <= 1'b1;
          end
          act_r <= act_rearm;
        end
        MODE_TEXT: begin
          act_r <= act_next;
        end
        MODE_TEXT_END: begin
          act_r <= act_rearm;
        end
        default: begin
          len_r <= '0;
          ovf_r <= 1'b0;
          act_r <= act_rearm;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && is_end) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_end) begin
      out_matched_r <= act_closed[len_r];
      out_ovf_r     <= ovf_r;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.matched          = out_matched_r;
  assign out_ch.pattern_overflow = out_ovf_r;

  // Checks
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(N))
    else $error("pattern length beyond store depth");

  a_act_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((act_r >> len_r) >> 1) == '0)
    else $error("active position beyond pattern length");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_end |=> out_vld_r)
    else $error("end of text produced no result word");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_mode_r == MODE_PAT_CLEAR) |=> (len_r == '0) && !ovf_r && (act_r == act_rearm))
    else $error("clear did not empty the pattern");

endmodule : glob_wildcard_matcher

`default_nettype wire

[bench/tb_glob_wildcard_matcher.sv]
// Self-checking bench for glob_wildcard_matcher: directed table, then random glob sessions.
// Depends on gm_pkg, gm_in_if, gm_out_if and the matcher RTL; results checked vs a local model.
`timescale 1ns / 1ps

module tb;
  import gm_pkg::*;

  localparam int MAX_PAT    = 32;
  localparam int RAND_WORDS = 800;
  localparam int CYCLE_CAP  = 400000;
  localparam int SETTLE     = 10;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  // One directed row: the word, how many times to send it, optional hand-typed verdict
  typedef struct packed {
    mode_t      mode;
    byte_t      data;
    logic [5:0] reps;
    logic       typed;
    verdict_t   want;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  gm_in_if  in_ch ();
  gm_out_if out_ch ();

  glob_wildcard_matcher #(.MAX_PATTERN(MAX_PAT)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Glob model state
  byte_t           pat_mem [MAX_PAT];
  int unsigned     pat_len  = 0;
  logic [MAX_PAT:0] live_pos = 1;
  logic            ovf_flag = 1'b0;

  verdict_t verdicts_due [$];

  bit tx_idle    = 1'b1;
  bit rx_idle    = 1'b1;
  int fail_cnt   = 0;
  int report_cnt = 0;
  int words_sent = 0;
  int cycle_cnt  = 0;

  // Directed words: empty text, star runs, zero and 0xFF literals, dead text,
  // store overflow, clear and append in the middle of a text
  stim_row_t directed_tab [0:29] = '{
    '{MODE_TEXT_END,   8'h5A,         6'd1,  1'b1, '{1'b1, 1'b0}},
    '{MODE_PAT_APPEND, STAR_BYTE,     6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_PAT_APPEND, "a",           6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_TEXT,       "b",           6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_TEXT,       "a",           6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_TEXT_END,   8'hFF,         6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_PAT_CLEAR,  8'hFF,         6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_PAT_APPEND, 8'h00,         6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_PAT_APPEND, 8'hFF,         6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_TEXT,       8'h00,         6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_TEXT,       8'hFF,         6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_TEXT_END,   8'h00,         6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_PAT_CLEAR,  8'h00,         6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_PAT_APPEND, QUESTION_BYTE, 6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_PAT_APPEND, "x",           6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_TEXT,       "y",           6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_TEXT,       "y",           6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_TEXT,       "x",           6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_TEXT_END,   8'h33,         6'd1,  1'b1, '{1'b0, 1'b0}},
    '{MODE_PAT_CLEAR,  8'hA5,         6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_PAT_APPEND, STAR_BYTE,     6'd33, 1'b0, '{1'b0, 1'b0}},
    '{MODE_TEXT_END,   8'hC3,         6'd1,  1'b1, '{1'b1, 1'b1}},
    '{MODE_TEXT,       "z",           6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_PAT_CLEAR,  8'h0F,         6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_PAT_APPEND, "a",           6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_TEXT,       "a",           6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_PAT_APPEND, "b",           6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_TEXT,       "a",           6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_TEXT,       "b",           6'd1,  1'b0, '{1'b0, 1'b0}},
    '{MODE_TEXT_END,   8'h81,         6'd1,  1'b0, '{1'b0, 1'b0}}
  };

  // Stars let activity skip ahead (empty run)
  function automatic void close_stars();
    for (int i = 0; i < pat_len; i++)
      if (live_pos[i] && pat_mem[i] == STAR_BYTE) live_pos[i+1] = 1'b1;
  endfunction

  // Advance the active set by one text byte
  function automatic void eat_text_byte(byte_t c);
    logic [MAX_PAT:0] nxt;
    close_stars();
    nxt = '0;
    for (int i = 0; i < pat_len; i++) begin
      if (live_pos[i]) begin
        if (pat_mem[i] == STAR_BYTE) nxt[i] = 1'b1;
        else if (pat_mem[i] == QUESTION_BYTE || pat_mem[i] == c) nxt[i+1] = 1'b1;
      end
    end
    live_pos = nxt;
    close_stars();
  endfunction

  // Model one accepted word; gives is set when it produces a verdict
  function automatic void apply_word(mode_t m, byte_t b, output bit gives,
                                     output verdict_t v);
    gives = 1'b0;
    v     = '0;
    case (m)
      MODE_PAT_APPEND: begin
        if (pat_len < MAX_PAT) begin
          pat_mem[pat_len] = b;
          pat_len++;
        end else begin
          ovf_flag = 1'b1;
        end
        live_pos = 1;
      end
      MODE_TEXT: begin
        eat_text_byte(b);
      end
      MODE_TEXT_END: begin
        close_stars();
        v.matched  = live_pos[pat_len];
        v.overflow = ovf_flag;
        gives      = 1'b1;
        live_pos   = 1;
      end
      MODE_PAT_CLEAR: begin
        pat_len  = 0;
        ovf_flag = 1'b0;
        live_pos = 1;
      end
    endcase
  endfunction

  // Text bytes lean on the pattern alphabet
  function automatic byte_t rand_text_byte();
    case ($urandom_range(0, 7))
      0, 1, 2: return "a";
      3:       return "b";
      4:       return "c";
      5:       return STAR_BYTE;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Drive one word, wait for the handshake, then update the model
  task automatic send_word(mode_t m, byte_t b, logic typed, verdict_t want);
    int       gap;
    bit       gives;
    verdict_t got;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= m;
    in_ch.byte_in <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    apply_word(m, b, gives, got);
    if (gives) verdicts_due.push_back(typed ? want : got);
    words_sent++;
  endtask

  // Hold off the sender until every pending verdict has come back
  task automatic drain_verdicts();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
  endtask

  // Result side: random stalls, compare against the oldest pending verdict
  initial begin : result_sink
    int       stall;
    verdict_t seen;
    verdict_t due;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      repeat (stall) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      seen.matched  = out_ch.matched;
      seen.overflow = out_ch.pattern_overflow;
      if (verdicts_due.size() == 0) begin
        fail_cnt++;
        if (report_cnt < 10)
          $display("unexpected result word: matched=%b overflow=%b",
                   seen.matched, seen.overflow);
        report_cnt++;
      end else begin
        due = verdicts_due.pop_front();
        if (seen.matched !== due.matched || seen.overflow !== due.overflow) begin
          fail_cnt++;
          if (report_cnt < 10)
            $display("result mismatch: matched exp %b got %b, overflow exp %b got %b",
                     due.matched, seen.matched, due.overflow, seen.overflow);
          report_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("[glob_wildcard_matcher] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int    row;
    int    n;
    int    i;
    int    kind;
    byte_t pb;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= MODE_PAT_CLEAR;
    in_ch.byte_in <= 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (row = 0; row < 30; row++)
      repeat (directed_tab[row].reps)
        send_word(directed_tab[row].mode, directed_tab[row].data,
                  directed_tab[row].typed, directed_tab[row].want);
    drain_verdicts();

    // Random glob sessions: mostly pattern, text, end; some noise and broken ones
    while (words_sent < RAND_WORDS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 9);
      if (kind == 0) begin
        n = $urandom_range(1, 8);
        repeat (n)
          send_word(mode_t'($urandom_range(0, 3)), byte_t'($urandom_range(0, 255)),
                    1'b0, '0);
      end else begin
        // new pattern, or reuse the stored one
        if (kind != 1) begin
          send_word(MODE_PAT_CLEAR, byte_t'($urandom_range(0, 255)), 1'b0, '0);
          n = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
          repeat (n) begin
            case ($urandom_range(0, 9))
              0, 1, 2: pb = STAR_BYTE;
              3, 4:    pb = QUESTION_BYTE;
              5, 6:    pb = "a";
              7:       pb = "b";
              8:       pb = "c";
              default: pb = byte_t'($urandom_range(0, 255));
            endcase
            send_word(MODE_PAT_APPEND, pb, 1'b0, '0);
          end
        end
        // text shaped to the stored pattern (rare mutations), or free text
        if ($urandom_range(0, 2) != 0) begin
          for (i = 0; i < pat_len; i++) begin
            if ($urandom_range(0, 15) == 0) begin
              send_word(MODE_TEXT, rand_text_byte(), 1'b0, '0);
            end else if (pat_mem[i] == STAR_BYTE) begin
              repeat ($urandom_range(0, 3)) send_word(MODE_TEXT, rand_text_byte(), 1'b0, '0);
            end else if (pat_mem[i] == QUESTION_BYTE) begin
              send_word(MODE_TEXT, rand_text_byte(), 1'b0, '0);
            end else begin
              send_word(MODE_TEXT, pat_mem[i], 1'b0, '0);
            end
          end
        end else begin
          n = $urandom_range(0, 10);
          repeat (n) send_word(MODE_TEXT, rand_text_byte(), 1'b0, '0);
        end
        // broken session: pattern touched mid-text
        if ($urandom_range(0, 9) == 0) begin
          send_word(($urandom_range(0, 1) != 0) ? MODE_PAT_APPEND : MODE_PAT_CLEAR,
                    byte_t'($urandom_range(0, 255)), 1'b0, '0);
          if ($urandom_range(0, 1) != 0) send_word(MODE_TEXT, rand_text_byte(), 1'b0, '0);
        end
        send_word(MODE_TEXT_END, byte_t'($urandom_range(0, 255)), 1'b0, '0);
      end
      if ($urandom_range(0, 19) == 0) drain_verdicts();
    end

    drain_verdicts();
    repeat (SETTLE) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[glob_wildcard_matcher] OK");
    end else begin
      $display("[glob_wildcard_matcher] ERROR");
    end
    $finish;
  end

endmodule : tb
